// ----- design/gcs_pkg.sv -----
// Shared types and constants for the gesture click and selection block.
`timescale 1ns / 1ps
package gcs_pkg;

  // Gesture state codes
  localparam logic [2:0] GS_IDLE  = 3'd0;
  localparam logic [2:0] GS_CLICK = 3'd5;
  localparam logic [2:0] G_FIST   = 3'd0;
  localparam logic [2:0] G_LAST   = 3'd4;

  // Selection state codes
  localparam logic [1:0] SEL_NONE       = 2'd0;
  localparam logic [1:0] SEL_FIRST      = 2'd1;
  localparam logic [1:0] SEL_CONFIRMING = 2'd2;

  // Item modes
  localparam logic [1:0] MODE_EVENT = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;

  // Register indexes
  localparam logic [1:0] REG_STABLE_COUNT = 2'd0;
  localparam logic [1:0] REG_CLICK_WINDOW = 2'd1;
  localparam logic [1:0] REG_CONFIRM_WAIT = 2'd2;

  // Register reset values
  localparam logic [3:0]  STABLE_COUNT_RST = 4'd3;
  localparam logic [15:0] CLICK_WINDOW_RST = 16'd500;
  localparam logic [15:0] CONFIRM_WAIT_RST = 16'd1000;

  // Gap reported while fewer than two events are in the history
  localparam logic [31:0] NO_GAP_MS = 32'd1000;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // latch the input beat
    logic write;   // push gesture into history, take the gap
    logic scan;    // walk the history for the stable check
    logic decide;  // update gesture and selection machines
    logic emit;    // load the result register
  } gcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_event;   // input beat is a valid gesture event
    logic scan_done;  // history walk finished
    logic out_free;   // result register can take a new beat
  } gcs_status_t;

endpackage

// ----- design/gesture_click_select_fsm.sv -----
// Top level of the gesture click and selection block.
//
//  channel  | direction | handshake          | contents
//  ---------+-----------+--------------------+-----------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | one event, clear or time poll per beat
//  m_*      | out       | m_tvalid/m_tready  | one result beat per input beat
//  cfg_*    | in        | cfg_we             | register writes, no read-back
//
// An event beat steps through accept, history write, a history walk, a decide step and a
// result load. The walk reads one older entry a cycle, none when stable_count is below 2 or
// too few entries are held, and stops early on a mismatch. Clear and poll beats go from
// accept straight to decide and load. One beat is in work at a time; a new beat is taken
// while the last result still waits. A stalled result register holds the controller in its
// load step. Reset (rst, synchronous) empties the history and returns both machines to idle.
`timescale 1ns / 1ps
module gesture_click_select_fsm
  import gcs_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // tdata: gesture[2:0], time_ms[34:3], corner_left_x[46:35], corner_top_y[58:47],
  //        corner_right_x[70:59], corner_bottom_y[82:71], zero[87:83]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // tdata: gesture_state[2:0], select_state[4:3], select_start[5], select_confirmed[6],
  //        sel_rect_x[18:7], sel_rect_y[30:19], sel_rect_width[43:31],
  //        sel_rect_height[56:44], zero[63:57]
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  gcs_cmd_t    cmd;
  gcs_status_t status;

  gcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gcs_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // A taken beat keeps the input closed until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input open right after an accepted beat");

  // A result load presents the beat and reopens the input
  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.out_free) |=> (m_tvalid && s_tready))
    else $error("result load did not present a beat");

  // The history walk runs only between the write and decide steps
  a_scan_no_input: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (!s_tready && !cmd.decide))
    else $error("history walk overlaps other steps");

  // Confirmation is reported only from the confirming state
  a_confirm_state: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[6]) |-> (m_tdata[4:3] == SEL_CONFIRMING))
    else $error("confirmed outside confirming state");

endmodule

// ----- design/gcs_ctrl.sv -----
// Sequencing controller for the gesture click and selection block.
`timescale 1ns / 1ps
module gcs_ctrl
  import gcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  gcs_status_t status,
  output gcs_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WRITE  = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  // Decode commands from the current state
  always_comb begin
    cmd        = '0;
    cmd.accept = (state == ST_IDLE) && s_tvalid;
    cmd.write  = (state == ST_WRITE);
    cmd.scan   = (state == ST_SCAN);
    cmd.decide = (state == ST_DECIDE);
    cmd.emit   = (state == ST_EMIT);
  end

  // Advance through write, scan, decide and emit; non-event beats go straight to decide
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = status.is_event ? ST_WRITE : ST_DECIDE;
      end
      ST_WRITE:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

// ----- design/gcs_datapath.sv -----
// History store, gesture and selection machines, and result register.
`timescale 1ns / 1ps
module gcs_datapath
  import gcs_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gcs_cmd_t              cmd,
  output gcs_status_t           status,
  input  logic [1:0]            s_tuser,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int AW   = $clog2(HISTORY_DEPTH);
  localparam int CNTW = $clog2(HISTORY_DEPTH + 1);
  localparam int CMPW = (CNTW > 4) ? CNTW : 4;
  localparam int SW   = CMPW + 1;
  localparam logic [AW-1:0]   LAST_SLOT = AW'(HISTORY_DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(HISTORY_DEPTH);
  localparam logic [SW-1:0]   DEPTH_S   = SW'(HISTORY_DEPTH);

  // Configuration registers
  logic [3:0]  stable_count;
  logic [15:0] click_window_ms;
  logic [15:0] confirm_wait_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_count    <= STABLE_COUNT_RST;
      click_window_ms <= CLICK_WINDOW_RST;
      confirm_wait_ms <= CONFIRM_WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STABLE_COUNT: stable_count    <= cfg_data[3:0];
        REG_CLICK_WINDOW: click_window_ms <= cfg_data;
        REG_CONFIRM_WAIT: confirm_wait_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latched input beat
  logic [1:0]  mode_q;
  logic [2:0]  g_q;
  logic [31:0] t_q;
  logic [11:0] lx_q, ty_q, rx_q, by_q;

  assign status.is_event = (s_tuser == MODE_EVENT) && (s_tdata[2:0] <= G_LAST);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q <= s_tuser;
      g_q    <= s_tdata[2:0];
      t_q    <= s_tdata[34:3];
      lx_q   <= s_tdata[46:35];
      ty_q   <= s_tdata[58:47];
      rx_q   <= s_tdata[70:59];
      by_q   <= s_tdata[82:71];
    end
  end

  // History ring: head, fill count and gap since the previous event
  logic [AW-1:0]   head;
  logic [CNTW-1:0] hist_count;
  logic [CNTW-1:0] hist_count_next;
  logic [31:0]     previous_time;
  logic [31:0]     gap;
  logic            gap_lt;
  logic            is_event_q;

  assign hist_count_next = (hist_count == FULL_CNT) ? hist_count : hist_count + 1'b1;
  assign gap = (hist_count_next >= CNTW'(2)) ? (t_q - previous_time) : NO_GAP_MS;

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      hist_count    <= '0;
      previous_time <= '0;
      is_event_q    <= 1'b0;
    end else begin
      if (cmd.accept) is_event_q <= status.is_event;
      if (cmd.write) begin
        head          <= (head == LAST_SLOT) ? '0 : head + 1'b1;
        hist_count    <= hist_count_next;
        previous_time <= t_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) gap_lt <= gap < {16'd0, click_window_ms};
  end

  // History store with one write and one registered read port
  logic [2:0]    hist_mem [HISTORY_DEPTH];
  logic [2:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic [3:0]    scan_i;
  logic          rd_pend;
  logic          stable;
  logic          issue;
  logic [SW-1:0] addr_sum;
  logic [SW-1:0] addr_wrap;

  // Slot of the entry scan_i places behind the newest one
  assign addr_sum  = SW'(head) + DEPTH_S - SW'(1) - SW'(scan_i);
  assign addr_wrap = (addr_sum >= DEPTH_S) ? addr_sum - DEPTH_S : addr_sum;
  assign rd_addr   = addr_wrap[AW-1:0];
  assign issue     = cmd.scan && stable && (scan_i < stable_count);

  always_ff @(posedge clk) begin
    if (cmd.write) hist_mem[head] <= g_q;
    if (issue)     rd_data <= hist_mem[rd_addr];
  end

  // Walk older entries one a cycle; drop stable on a mismatch
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (cmd.write) begin
      rd_pend <= 1'b0;
    end else if (cmd.scan) begin
      rd_pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      stable <= CMPW'(hist_count_next) >= CMPW'(stable_count);
      scan_i <= 4'd1;
    end else if (cmd.scan) begin
      if (issue) scan_i <= scan_i + 4'd1;
      if (rd_pend && (rd_data != g_q)) stable <= 1'b0;
    end
  end

  assign status.scan_done = !issue && !rd_pend;

  // Gesture and selection machines
  logic [2:0]  gesture_fsm;
  logic [2:0]  gesture_fsm_next;
  logic [1:0]  select_fsm;
  logic [31:0] confirm_start_time;
  logic [11:0] rect_x, rect_y;
  logic [12:0] rect_w, rect_h;

  always_comb begin
    gesture_fsm_next = gesture_fsm;
    if (is_event_q) begin
      if (gesture_fsm == GS_IDLE) begin
        if ((g_q != G_FIST) && stable) gesture_fsm_next = g_q;
      end else if (gesture_fsm == GS_CLICK) begin
        gesture_fsm_next = GS_IDLE;
      end else if ((g_q != gesture_fsm) && stable) begin
        gesture_fsm_next = gap_lt ? GS_CLICK : GS_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gesture_fsm        <= GS_IDLE;
      select_fsm         <= SEL_NONE;
      confirm_start_time <= '0;
      rect_x             <= '0;
      rect_y             <= '0;
      rect_w             <= '0;
      rect_h             <= '0;
    end else if (cmd.decide) begin
      gesture_fsm <= gesture_fsm_next;
      if (mode_q == MODE_CLEAR) begin
        select_fsm <= SEL_NONE;
      end else if (is_event_q && (gesture_fsm_next == GS_CLICK)) begin
        if (select_fsm == SEL_NONE) begin
          select_fsm <= SEL_FIRST;
        end else if (select_fsm == SEL_FIRST) begin
          rect_x             <= lx_q;
          rect_y             <= ty_q;
          rect_w             <= {1'b0, rx_q} - {1'b0, lx_q};
          rect_h             <= {1'b0, by_q} - {1'b0, ty_q};
          select_fsm         <= SEL_CONFIRMING;
          confirm_start_time <= t_q;
        end
      end
    end
  end

  // Result register
  logic confirmed;

  assign confirmed = (select_fsm == SEL_CONFIRMING) &&
                     ((t_q - confirm_start_time) > {16'd0, confirm_wait_ms});
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit && status.out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && status.out_free) begin
      m_tdata <= {7'd0, rect_h, rect_w, rect_y, rect_x, confirmed,
                  select_fsm == SEL_FIRST, select_fsm, gesture_fsm};
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench for the gesture click and selection block: directed table, random runs, scoreboard.
`timescale 1ns / 1ps
module tb;
  import gcs_pkg::*;

  localparam int HISTORY_DEPTH = 8;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int NUM_PHASES = 8;
  localparam int EXP_DEPTH = 16;
  localparam int MAX_ROWS = 32;

  // Mode and gesture codes not named in the package
  localparam logic [1:0] MODE_POLL = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam logic [2:0] G_PALM   = 3'd1;
  localparam logic [2:0] G_PLS    = 3'd2;
  localparam logic [2:0] G_HOLE   = 3'd3;
  localparam logic [2:0] G_FOUR   = 3'd4;
  localparam logic [2:0] G_BAD    = 3'd7;

  // One input beat; everything below mode maps onto tdata from the lowest bit up
  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] bottom_y;
    logic [11:0] right_x;
    logic [11:0] top_y;
    logic [11:0] left_x;
    logic [31:0] time_ms;
    logic [2:0]  gesture;
  } gesture_item_t;

  // One result beat, lowest field last
  typedef struct packed {
    logic [12:0] height;
    logic [12:0] width;
    logic [11:0] ry;
    logic [11:0] rx;
    logic        confirmed;
    logic        start;
    logic [1:0]  sel;
    logic [2:0]  gstate;
  } result_t;

  typedef struct {
    gesture_item_t item;
    bit            typed;
    result_t       want;
  } dir_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic [1:0]            cfg_index = '0;
  logic [15:0]           cfg_data = '0;

  gesture_click_select_fsm #(.HISTORY_DEPTH(HISTORY_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state and its copy of the registers
  logic [2:0]  hist_types [HISTORY_DEPTH];
  int          hist_head = 0;
  int          hist_fill = 0;
  logic [31:0] last_event_ms = '0;
  logic [2:0]  gest_state = GS_IDLE;
  logic [1:0]  sel_state = SEL_NONE;
  logic [31:0] confirm_t0 = '0;
  logic [11:0] rect_x = '0;
  logic [11:0] rect_y = '0;
  logic [12:0] rect_w = '0;
  logic [12:0] rect_h = '0;
  logic [3:0]  cfg_stable = STABLE_COUNT_RST;
  logic [15:0] cfg_window = CLICK_WINDOW_RST;
  logic [15:0] cfg_wait = CONFIRM_WAIT_RST;

  // Pending expectations as a ring with free-running write and read counts
  result_t     expected_results [EXP_DEPTH];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          mismatch_count = 0;
  logic [31:0] now_ms = '0;
  bit          sender_calm = 1'b0;
  dir_row_t    directed_rows [MAX_ROWS];
  int          n_rows = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Gesture is stable when the newest cfg_stable history entries all hold it
  function automatic bit is_settled(logic [2:0] g);
    int k;
    if (hist_fill < int'(cfg_stable)) return 1'b0;
    for (k = 0; k < int'(cfg_stable); k++) begin
      if (hist_types[(hist_head + HISTORY_DEPTH - 1 - k) % HISTORY_DEPTH] != g) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance both machines by one item and return the result beat it yields
  function automatic result_t gesture_step(gesture_item_t it);
    logic [31:0] gap;
    logic [31:0] elapsed;
    result_t     r;
    gap = NO_GAP_MS;
    if (it.mode == MODE_EVENT && it.gesture <= G_LAST) begin
      hist_types[hist_head] = it.gesture;
      hist_head = (hist_head + 1) % HISTORY_DEPTH;
      if (hist_fill < HISTORY_DEPTH) hist_fill++;
      if (hist_fill >= 2) gap = it.time_ms - last_event_ms;
      last_event_ms = it.time_ms;
      if (gest_state == GS_IDLE) begin
        if (it.gesture != G_FIST && is_settled(it.gesture)) gest_state = it.gesture;
      end else if (gest_state == GS_CLICK) begin
        gest_state = GS_IDLE;
      end else if (it.gesture != gest_state && is_settled(it.gesture)) begin
        gest_state = (gap < {16'd0, cfg_window}) ? GS_CLICK : GS_IDLE;
      end
      if (gest_state == GS_CLICK) begin
        if (sel_state == SEL_NONE) begin
          sel_state = SEL_FIRST;
        end else if (sel_state == SEL_FIRST) begin
          rect_x = it.left_x;
          rect_y = it.top_y;
          rect_w = {1'b0, it.right_x} - {1'b0, it.left_x};
          rect_h = {1'b0, it.bottom_y} - {1'b0, it.top_y};
          sel_state = SEL_CONFIRMING;
          confirm_t0 = it.time_ms;
        end
      end
    end else if (it.mode == MODE_CLEAR) begin
      sel_state = SEL_NONE;
    end
    elapsed = it.time_ms - confirm_t0;
    r.gstate = gest_state;
    r.sel = sel_state;
    r.start = (sel_state == SEL_FIRST);
    r.confirmed = (sel_state == SEL_CONFIRMING) && (elapsed > {16'd0, cfg_wait});
    r.rx = rect_x;
    r.ry = rect_y;
    r.width = rect_w;
    r.height = rect_h;
    return r;
  endfunction

  function automatic logic [11:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 12'h000;
      1: return 12'hFFF;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] event_gap();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1, 2: return {16'd0, cfg_window} + $urandom_range(0, 200);
      default: return $urandom_range(0, cfg_window);
    endcase
  endfunction

  function automatic gesture_item_t make_item(logic [1:0] m, logic [2:0] g, logic [31:0] t);
    gesture_item_t it;
    it.mode = m;
    it.gesture = g;
    it.time_ms = t;
    it.left_x = rand_coord();
    it.top_y = rand_coord();
    it.right_x = rand_coord();
    it.bottom_y = rand_coord();
    return it;
  endfunction

  task automatic add_row(logic [1:0] m, logic [2:0] g, logic [31:0] t, logic [11:0] lx,
                         logic [11:0] ty, logic [11:0] rx, logic [11:0] by, bit typed,
                         result_t want);
    dir_row_t row;
    row.item = '{mode: m, bottom_y: by, right_x: rx, top_y: ty, left_x: lx,
                 time_ms: t, gesture: g};
    row.typed = typed;
    row.want = want;
    directed_rows[n_rows] = row;
    n_rows++;
  endtask

  task automatic cmp_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Drive one beat after a random gap (none while the sender is calm); record its expectation once it is taken
  task automatic send_item(gesture_item_t it, bit typed, result_t want);
    int      gap;
    result_t predicted;
    gap = sender_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, it[82:0]};
    s_tuser <= it.mode;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    predicted = gesture_step(it);
    expected_results[exp_wr % EXP_DEPTH] = typed ? want : predicted;
    exp_wr++;
  endtask

  // Register write; caller lowers the write enable after the last one
  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_STABLE_COUNT: cfg_stable = val[3:0];
      REG_CLICK_WINDOW: cfg_window = val;
      REG_CONFIRM_WAIT: cfg_wait = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain_expected();
    s_tvalid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
  endtask

  // Random phase: mostly well-formed gesture runs, plus polls, clears and noise
  task automatic run_phase(int n_items);
    int            counted;
    int            pick;
    int            len;
    logic [2:0]    g;
    logic [31:0]   t;
    gesture_item_t it;
    counted = 0;
    while (counted < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        g = 3'($urandom_range(0, 4));
        len = int'(cfg_stable) + $urandom_range(0, 2);
        if (len == 0) len = 1;
        repeat (len) begin
          now_ms = now_ms + event_gap();
          send_item(make_item(MODE_EVENT, g, now_ms), 1'b0, '0);
          counted++;
        end
      end else if (pick < 78) begin
        if (sel_state == SEL_CONFIRMING && $urandom_range(0, 1) == 1)
          t = confirm_t0 + {16'd0, cfg_wait} + $urandom_range(0, 2) - 1;
        else
          t = now_ms + $urandom_range(0, 3000);
        send_item(make_item(MODE_POLL, 3'($urandom), t), 1'b0, '0);
        counted++;
      end else if (pick < 85) begin
        send_item(make_item(MODE_CLEAR, 3'($urandom), now_ms), 1'b0, '0);
        counted++;
      end else if (pick < 92) begin
        // broken run: a lone gesture
        now_ms = now_ms + event_gap();
        send_item(make_item(MODE_EVENT, 3'($urandom_range(0, 4)), now_ms), 1'b0, '0);
        counted++;
      end else begin
        // ignored beats: reserved mode or gesture code past four
        if ($urandom_range(0, 1) == 1)
          it = make_item(MODE_RSVD, 3'($urandom), $urandom);
        else
          it = make_item(MODE_EVENT, 3'($urandom_range(G_LAST + 1, G_BAD)), $urandom);
        send_item(it, 1'b0, '0);
        counted++;
      end
    end
  endtask

  // Result side: random stalls, two long hold-offs, field-by-field check
  initial begin : result_sink
    int          hold;
    int          beats;
    bit          calm;
    result_t     got;
    logic [6:0]  pad;
    result_t     want;
    beats = 0;
    calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (beats == 300 || beats == 900) hold = 150;
      else hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      got = m_tdata[56:0];
      pad = m_tdata[63:57];
      @(posedge clk);
      if (exp_wr == exp_rd) begin
        $error("result beat with no expectation pending");
        mismatch_count++;
      end else begin
        want = expected_results[exp_rd % EXP_DEPTH];
        exp_rd++;
        cmp_field("gesture_state", want.gstate, got.gstate);
        cmp_field("select_state", want.sel, got.sel);
        cmp_field("select_start", want.start, got.start);
        cmp_field("select_confirmed", want.confirmed, got.confirmed);
        cmp_field("sel_rect_x", want.rx, got.rx);
        cmp_field("sel_rect_y", want.ry, got.ry);
        cmp_field("sel_rect_width", want.width, got.width);
        cmp_field("sel_rect_height", want.height, got.height);
        cmp_field("tdata_pad", 0, pad);
      end
      beats++;
      if (beats % 50 == 0) calm = ($urandom_range(0, 3) == 0);
    end
  end

  // Stimulus
  initial begin : stimulus
    int          p;
    int          i;
    result_t     zero_res;
    result_t     latched;
    result_t     latched_ok;
    logic [15:0] ph_stable [7];
    logic [15:0] ph_window [7];
    logic [15:0] ph_wait [7];
    zero_res = '0;
    latched = '{gstate: GS_CLICK, sel: SEL_CONFIRMING, start: 1'b0, confirmed: 1'b0,
                rx: 12'hFFF, ry: 12'hFFF, width: 13'h1001, height: 13'h1001};
    latched_ok = latched;
    latched_ok.confirmed = 1'b1;
    ph_stable = '{16'd1, 16'd2, 16'd0, 16'd8, 16'd15, 16'd5, 16'd3};
    ph_window = '{16'd65535, 16'd300, 16'd1000, 16'd65535, 16'd0, 16'd0, 16'd800};
    ph_wait   = '{16'd0, 16'd500, 16'd65535, 16'd2000, 16'd100, 16'd65535, 16'd1000};

    // Directed rows, register reset values
    add_row(MODE_POLL, G_FIST, 32'd0, 0, 0, 0, 0, 1'b1, zero_res);
    add_row(MODE_RSVD, G_PALM, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1,
            zero_res);
    add_row(MODE_EVENT, G_BAD, 32'd10, 0, 0, 0, 0, 1'b1, zero_res);
    add_row(MODE_EVENT, G_FIST, 32'd10, 0, 0, 0, 0, 1'b1, zero_res);
    // palm settles into its hold state, then repeats while held
    add_row(MODE_EVENT, G_PALM, 32'd100, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_PALM, 32'd200, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_PALM, 32'd300, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_PALM, 32'd350, 0, 0, 0, 0, 1'b0, zero_res);
    // quick change to the second gesture: first click, first corner
    add_row(MODE_EVENT, G_PLS, 32'd400, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_PLS, 32'd450, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_PLS, 32'd500, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_FIST, 32'd600, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_HOLE, 32'd700, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_HOLE, 32'd800, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_HOLE, 32'd900, 0, 0, 0, 0, 1'b0, zero_res);
    // second click latches the most negative rectangle
    add_row(MODE_EVENT, G_FOUR, 32'd950, 12'hFFF, 12'hFFF, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_FOUR, 32'd1000, 12'hFFF, 12'hFFF, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_FOUR, 32'd1100, 12'hFFF, 12'hFFF, 0, 0, 1'b1, latched);
    // confirm edge: equal is not enough, one more counts, a backward time wraps
    add_row(MODE_POLL, G_FIST, 32'd2100, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_POLL, G_FIST, 32'd2101, 0, 0, 0, 0, 1'b1, latched_ok);
    add_row(MODE_POLL, G_FIST, 32'd1099, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_CLEAR, G_FIST, 32'd0, 0, 0, 0, 0, 1'b0, zero_res);
    // click falls back to idle; event gap wraps past the top of time
    add_row(MODE_EVENT, G_PALM, 32'hFFFF_FFFF, 0, 12'hFFF, 12'hFFF, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_PALM, 32'd5, 0, 0, 0, 0, 1'b0, zero_res);
    add_row(MODE_EVENT, G_PALM, 32'd6, 0, 0, 0, 0, 1'b0, zero_res);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < n_rows; i++)
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    drain_expected();
    now_ms = 32'd10;

    // Random phases, each under its own register setting
    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < 7) begin
        set_reg(REG_STABLE_COUNT, ph_stable[p]);
        set_reg(REG_CLICK_WINDOW, ph_window[p]);
        set_reg(REG_CONFIRM_WAIT, ph_wait[p]);
      end else begin
        set_reg(REG_STABLE_COUNT, 16'($urandom_range(0, 15)));
        set_reg(REG_CLICK_WINDOW, 16'($urandom));
        set_reg(REG_CONFIRM_WAIT, 16'($urandom));
      end
      cfg_we <= 1'b0;
      sender_calm = (p == 2 || p == 5);
      run_phase(ITEMS_PER_PHASE);
      drain_expected();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
design/gcs_pkg.sv
design/gcs_ctrl.sv
design/gcs_datapath.sv
design/gesture_click_select_fsm.sv
tb/sv/tb.sv
